// ===== rtl/core/msp_rx_pkg.sv =====
// Shared types and constants for the MSP / stop-character frame receiver.
// No dependencies; used by msp_rx_step and msp_or_stopchar_frame_receiver.
package msp_rx_pkg;

  localparam int unsigned MAX_BUFFER = 4096;
  localparam int unsigned IDX_W      = $clog2(MAX_BUFFER + 1);  // byte index and limit
  localparam int unsigned POS_W      = $clog2(MAX_BUFFER);      // stored position

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_ARROW  = 8'h3C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [IDX_W-1:0] LIMIT_MAX = IDX_W'(MAX_BUFFER);

  typedef enum logic [1:0] {
    MODE_STOPCHAR = 2'd0,
    MODE_MSP      = 2'd1,
    MODE_CUSTOM   = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_STOP    = 2'd1,
    REG_LIMIT   = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } in_cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_M,
    PH_ARROW,
    PH_SIZE,
    PH_CMD
  } phase_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  stop_char;
    logic [12:0] buffer_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       payload_size;
    logic [7:0]       checksum;
    logic [7:0]       command;
    logic [15:0]      idle_count;
  } state_t;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] store_index;
    logic             frame_done;
    logic [IDX_W-1:0] frame_length;
    logic [7:0]       msp_command;
    logic             checksum_error;
    logic             oversize_reject;
    logic             overflow;
    logic             timeout_reset;
  } result_t;

endpackage

// ===== rtl/core/msp_rx_step.sv =====
// Per-word framing logic: next receiver state and the result for one word.
// Depends on msp_rx_pkg.
module msp_rx_step (
  input  msp_rx_pkg::cfg_t    cfg,
  input  msp_rx_pkg::state_t  cur,
  input  msp_rx_pkg::in_cmd_t command,
  input  logic [7:0]          rx_byte,
  output msp_rx_pkg::state_t  nxt,
  output msp_rx_pkg::result_t res
);

  logic [msp_rx_pkg::IDX_W-1:0] limit;
  logic                         ovf;
  logic [msp_rx_pkg::IDX_W-1:0] idx0;
  logic [7:0]                   cmd0;
  logic [15:0]                  idle_inc;
  logic                         in_payload;
  logic                         csum_ok;
  msp_rx_pkg::phase_t           phase_nxt;

  assign limit = (cfg.buffer_limit > msp_rx_pkg::LIMIT_MAX) ? msp_rx_pkg::LIMIT_MAX
                                                            : cfg.buffer_limit;
  assign ovf        = (cur.byte_index >= limit);
  assign idx0       = ovf ? '0 : cur.byte_index;
  assign cmd0       = ovf ? 8'h00 : cur.command;
  assign idle_inc   = (cur.idle_count == 16'hFFFF) ? cur.idle_count : cur.idle_count + 16'd1;
  assign in_payload = ({{(msp_rx_pkg::IDX_W-8){1'b0}}, cur.payload_size} > idx0);
  assign csum_ok    = (cur.checksum == rx_byte);

  // MSP header and payload sequencing
  always_comb begin
    phase_nxt = cur.phase;
    if (command == msp_rx_pkg::CMD_BYTE && cfg.mode == msp_rx_pkg::MODE_MSP) begin
      case (cur.phase)
        msp_rx_pkg::PH_IDLE:
          phase_nxt = (rx_byte == msp_rx_pkg::CH_DOLLAR) ? msp_rx_pkg::PH_DOLLAR
                                                         : msp_rx_pkg::PH_IDLE;
        msp_rx_pkg::PH_DOLLAR:
          phase_nxt = (rx_byte == msp_rx_pkg::CH_M) ? msp_rx_pkg::PH_M : msp_rx_pkg::PH_IDLE;
        msp_rx_pkg::PH_M:
          phase_nxt = (rx_byte == msp_rx_pkg::CH_ARROW) ? msp_rx_pkg::PH_ARROW
                                                        : msp_rx_pkg::PH_IDLE;
        msp_rx_pkg::PH_ARROW:
          phase_nxt = ({{(msp_rx_pkg::IDX_W-8){1'b0}}, rx_byte} > limit) ? msp_rx_pkg::PH_IDLE
                                                                          : msp_rx_pkg::PH_SIZE;
        msp_rx_pkg::PH_SIZE:
          phase_nxt = msp_rx_pkg::PH_CMD;
        msp_rx_pkg::PH_CMD:
          phase_nxt = in_payload ? msp_rx_pkg::PH_CMD : msp_rx_pkg::PH_IDLE;
        default:
          phase_nxt = msp_rx_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    nxt       = cur;
    nxt.phase = phase_nxt;
    res       = '0;
    if (command == msp_rx_pkg::CMD_TICK) begin
      nxt.idle_count = idle_inc;
      if (cur.byte_index != '0 && idle_inc > cfg.timeout_ticks) begin
        nxt.byte_index    = '0;
        nxt.command       = 8'h00;
        res.timeout_reset = 1'b1;
      end
      res.msp_command = nxt.command;
    end else begin
      nxt.idle_count = '0;
      nxt.byte_index = idx0;
      nxt.command    = cmd0;
      res.overflow   = ovf;
      case (cfg.mode)
        msp_rx_pkg::MODE_STOPCHAR: begin
          res.data_valid  = 1'b1;
          res.store_index = idx0[msp_rx_pkg::POS_W-1:0];
          nxt.byte_index  = idx0 + 1'b1;
          if (rx_byte == cfg.stop_char) begin
            res.data_byte    = msp_rx_pkg::CH_NUL;
            res.frame_done   = 1'b1;
            res.frame_length = idx0 + 1'b1;
          end else begin
            res.data_byte = rx_byte;
          end
        end
        msp_rx_pkg::MODE_MSP: begin
          case (cur.phase)
            msp_rx_pkg::PH_ARROW: begin
              if ({{(msp_rx_pkg::IDX_W-8){1'b0}}, rx_byte} > limit) begin
                res.oversize_reject = 1'b1;
              end else begin
                nxt.payload_size = rx_byte;
                nxt.byte_index   = '0;
                nxt.checksum     = rx_byte;
              end
            end
            msp_rx_pkg::PH_SIZE: begin
              nxt.command  = rx_byte;
              nxt.checksum = cur.checksum ^ rx_byte;
            end
            msp_rx_pkg::PH_CMD: begin
              if (in_payload) begin
                nxt.checksum    = cur.checksum ^ rx_byte;
                res.data_valid  = 1'b1;
                res.data_byte   = rx_byte;
                res.store_index = idx0[msp_rx_pkg::POS_W-1:0];
                nxt.byte_index  = idx0 + 1'b1;
              end else if (csum_ok) begin
                res.frame_done   = 1'b1;
                res.frame_length = idx0;
              end else begin
                res.checksum_error = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;  // custom and reserved modes drop the byte
      endcase
      res.msp_command = nxt.command;
      // a completed message is consumed at once
      if (res.frame_done) begin
        nxt.byte_index = '0;
        nxt.command    = 8'h00;
      end
    end
  end

endmodule

// ===== rtl/core/msp_or_stopchar_frame_receiver.sv =====
// Top level of the serial frame receiver: handshakes, configuration registers,
// input and result registers. Depends on msp_rx_pkg and msp_rx_step.
//
// Usage: each input word is either a received serial byte (in_tuser = 0,
// byte in in_tdata) or a one-millisecond tick (in_tuser = 1). Every input
// word yields exactly one result word. out_tuser flags a stored message
// byte, out_tlast marks the word that completes a valid message.
// Words pass an input register, then the framing logic, then the result
// register; one word per cycle is sustained while out_tready is high.
// The framing state is updated in the same cycle a word moves from the
// input register to the result register.
// When the result side stalls, the result register holds and the input
// register fills; in_tready drops only when both are occupied and
// out_tready is low.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready, one register
// per write; write only while no word is in flight.
// Reset (rst_n low, synchronous): both pipeline registers empty, framing
// state cleared, configuration back to stop-character mode, stop char ';',
// limit 256, timeout 1000 ticks.
module msp_or_stopchar_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] data_byte, [19:8] store_index,
                                  // [32:20] frame_length, [40:33] msp_command,
                                  // [41] checksum_error, [42] oversize_reject,
                                  // [43] overflow, [44] timeout_reset, [47:45] zero
  output logic        out_tlast,  // frame_done
  output logic        out_tuser,  // [0] data_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  msp_rx_pkg::cfg_t    cfg_r;
  msp_rx_pkg::state_t  st_r, st_nxt;
  msp_rx_pkg::result_t res_nxt, res_r;
  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  msp_rx_pkg::in_cmd_t s1_cmd_r;
  logic                out_valid_r;
  logic                out_adv;
  logic                s1_adv;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= msp_rx_pkg::MODE_STOPCHAR;
      cfg_r.stop_char     <= 8'd59;
      cfg_r.buffer_limit  <= 13'd256;
      cfg_r.timeout_ticks <= 16'd1000;
    end else if (cfg_valid) begin
      case (msp_rx_pkg::reg_idx_t'(cfg_index))
        msp_rx_pkg::REG_MODE:    cfg_r.mode          <= msp_rx_pkg::mode_t'(cfg_data[1:0]);
        msp_rx_pkg::REG_STOP:    cfg_r.stop_char     <= cfg_data[7:0];
        msp_rx_pkg::REG_LIMIT:   cfg_r.buffer_limit  <= cfg_data[12:0];
        msp_rx_pkg::REG_TIMEOUT: cfg_r.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_cmd_r  <= msp_rx_pkg::in_cmd_t'(in_tuser);
    end
  end

  msp_rx_step u_step (
    .cfg     (cfg_r),
    .cur     (st_r),
    .command (s1_cmd_r),
    .rx_byte (s1_byte_r),
    .nxt     (st_nxt),
    .res     (res_nxt)
  );

  // advance framing state once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= msp_rx_pkg::PH_IDLE;
      st_r.byte_index   <= '0;
      st_r.payload_size <= '0;
      st_r.checksum     <= '0;
      st_r.command      <= '0;
      st_r.idle_count   <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.data_valid;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {3'b000,
                       res_r.timeout_reset,
                       res_r.overflow,
                       res_r.oversize_reject,
                       res_r.checksum_error,
                       res_r.msp_command,
                       res_r.frame_length,
                       res_r.store_index,
                       res_r.data_byte};

endmodule
